### rtl/tdf_pkg.sv
// tdf_pkg: shared widths, result kinds, control word layout and the
// microcode program of the trial division factorizer
// no dependencies
package tdf_pkg;

  localparam int VALUE_BITS = 34;
  localparam int PC_BITS    = 4;

  // result kind codes
  typedef enum logic [1:0] {
    KIND_FACTOR = 2'd0,
    KIND_ONE    = 2'd1,
    KIND_ZERO   = 2'd2
  } kind_t;

  // what a step waits for before it executes
  typedef enum logic [1:0] {
    H_NONE,
    H_IN,
    H_OUT,
    H_DIV
  } hold_t;

  // datapath operation of a step
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_EMIT_ZERO,
    OP_EMIT_ONE,
    OP_EMIT_TWO,
    OP_DIV_START,
    OP_EMIT_DIV,
    OP_NEXT_DIV,
    OP_EMIT_REST
  } op_t;

  // branch condition, taken jumps go to target
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_ZERO,
    C_ONE,
    C_ODD,
    C_DIV_GT_Q,
    C_REM_NZ
  } cond_t;

  typedef logic [PC_BITS-1:0] pc_t;

  typedef struct packed {
    hold_t hold;
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ucode_t;

  // program entry points
  localparam pc_t PC_IDLE      = 4'd0;
  localparam pc_t PC_TWOS      = 4'd3;
  localparam pc_t PC_ODD_CHK   = 4'd5;
  localparam pc_t PC_TRY       = 4'd6;
  localparam pc_t PC_DIV_HIT   = 4'd9;
  localparam pc_t PC_STEP      = 4'd10;
  localparam pc_t PC_FINAL     = 4'd11;
  localparam pc_t PC_EMIT_ZERO = 4'd12;
  localparam pc_t PC_EMIT_ONE  = 4'd13;

  // control store
  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t cw;
    case (pc)
      4'd0:    cw = '{H_IN,   OP_LOAD,      C_NEVER,    PC_IDLE};
      4'd1:    cw = '{H_NONE, OP_NONE,      C_ZERO,     PC_EMIT_ZERO};
      4'd2:    cw = '{H_NONE, OP_NONE,      C_ONE,      PC_EMIT_ONE};
      4'd3:    cw = '{H_NONE, OP_NONE,      C_ODD,      PC_ODD_CHK};
      4'd4:    cw = '{H_OUT,  OP_EMIT_TWO,  C_ALWAYS,   PC_TWOS};
      4'd5:    cw = '{H_NONE, OP_NONE,      C_ONE,      PC_IDLE};
      4'd6:    cw = '{H_NONE, OP_DIV_START, C_NEVER,    PC_IDLE};
      4'd7:    cw = '{H_DIV,  OP_NONE,      C_DIV_GT_Q, PC_FINAL};
      4'd8:    cw = '{H_NONE, OP_NONE,      C_REM_NZ,   PC_STEP};
      4'd9:    cw = '{H_OUT,  OP_EMIT_DIV,  C_ALWAYS,   PC_TRY};
      4'd10:   cw = '{H_NONE, OP_NEXT_DIV,  C_ALWAYS,   PC_TRY};
      4'd11:   cw = '{H_OUT,  OP_EMIT_REST, C_ALWAYS,   PC_IDLE};
      4'd12:   cw = '{H_OUT,  OP_EMIT_ZERO, C_ALWAYS,   PC_IDLE};
      4'd13:   cw = '{H_OUT,  OP_EMIT_ONE,  C_ALWAYS,   PC_IDLE};
      default: cw = '{H_NONE, OP_NONE,      C_ALWAYS,   PC_IDLE};
    endcase
    return cw;
  endfunction

endpackage

### rtl/tdf_divider.sv
// tdf_divider: restoring divider, one quotient bit per cycle
// depends on tdf_pkg for the value width
module tdf_divider (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [tdf_pkg::VALUE_BITS-1:0] dividend,
  input  logic [tdf_pkg::VALUE_BITS-1:0] divisor,
  output logic                           busy,
  output logic [tdf_pkg::VALUE_BITS-1:0] quotient,
  output logic [tdf_pkg::VALUE_BITS-1:0] remainder
);
  import tdf_pkg::*;

  localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] quo_r;
  logic [VALUE_BITS-1:0] rem_r;
  logic [VALUE_BITS-1:0] dsr_r;
  logic [CNT_BITS-1:0]   cnt_r;
  logic                  busy_r;
  logic [VALUE_BITS:0]   shifted;
  logic [VALUE_BITS:0]   trial;

  // shift in next dividend bit and try the subtract
  assign shifted = {rem_r, quo_r[VALUE_BITS-1]};
  assign trial   = shifted - {1'b0, dsr_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_BITS'(VALUE_BITS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      if (!trial[VALUE_BITS]) begin
        rem_r <= trial[VALUE_BITS-1:0];
        quo_r <= {quo_r[VALUE_BITS-2:0], 1'b1};
      end else begin
        rem_r <= shifted[VALUE_BITS-1:0];
        quo_r <= {quo_r[VALUE_BITS-2:0], 1'b0};
      end
    end
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

### rtl/trial_division_factorizer.sv
// trial_division_factorizer: microcoded trial division prime factorizer
// Factors of two are stripped by shifting the rest; each odd divisor tried takes one
// bit-serial division of the rest (remainder and quotient), and each result an output step.
// Throughput: one word at a time; in_stall stays high until the step counter is back at idle.
// Reset: synchronous active-low rst_n returns the step counter to idle and
// empties the output register; no clearing pass is needed.
module trial_division_factorizer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tdf_pkg::VALUE_BITS-1:0] in_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tdf_pkg::VALUE_BITS-1:0] out_factor,
  output logic [1:0]                     out_kind,
  output logic                           out_last
);
  import tdf_pkg::*;

  pc_t                   pc_r, pc_nxt;
  logic [VALUE_BITS-1:0] rest_r, rest_nxt;
  logic [VALUE_BITS-1:0] div_r, div_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0] out_factor_r, out_factor_nxt;
  kind_t                 out_kind_r, out_kind_nxt;
  logic                  out_last_r, out_last_nxt;

  ucode_t                cw;
  logic                  hold_ok;
  logic                  cond_true;
  logic                  out_free;
  logic                  div_start;
  logic                  div_busy;
  logic [VALUE_BITS-1:0] div_quo;
  logic [VALUE_BITS-1:0] div_rem;

  // current control word
  assign cw       = ucode_rom(pc_r);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (cw.hold != H_IN);

  // step hold
  always_comb begin
    case (cw.hold)
      H_NONE:  hold_ok = 1'b1;
      H_IN:    hold_ok = in_valid;
      H_OUT:   hold_ok = out_free;
      H_DIV:   hold_ok = !div_busy;
      default: hold_ok = 1'b0;
    endcase
  end

  // branch condition
  always_comb begin
    case (cw.cond)
      C_NEVER:    cond_true = 1'b0;
      C_ALWAYS:   cond_true = 1'b1;
      C_ZERO:     cond_true = (rest_r == '0);
      C_ONE:      cond_true = (rest_r == VALUE_BITS'(1));
      C_ODD:      cond_true = rest_r[0];
      C_DIV_GT_Q: cond_true = (div_r > div_quo);
      C_REM_NZ:   cond_true = (div_rem != '0);
      default:    cond_true = 1'b0;
    endcase
  end

  assign div_start = hold_ok && (cw.op == OP_DIV_START);

  // sequencer and datapath next values
  always_comb begin
    pc_nxt         = pc_r;
    rest_nxt       = rest_r;
    div_nxt        = div_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_factor_nxt = out_factor_r;
    out_kind_nxt   = out_kind_r;
    out_last_nxt   = out_last_r;
    if (hold_ok) begin
      pc_nxt = cond_true ? cw.target : pc_r + 1'b1;
      case (cw.op)
        OP_LOAD: begin
          rest_nxt = in_value;
          div_nxt  = VALUE_BITS'(3);
        end
        OP_EMIT_ZERO: begin
          out_valid_nxt  = 1'b1;
          out_factor_nxt = '0;
          out_kind_nxt   = KIND_ZERO;
          out_last_nxt   = 1'b1;
        end
        OP_EMIT_ONE: begin
          out_valid_nxt  = 1'b1;
          out_factor_nxt = '0;
          out_kind_nxt   = KIND_ONE;
          out_last_nxt   = 1'b1;
        end
        OP_EMIT_TWO: begin
          out_valid_nxt  = 1'b1;
          out_factor_nxt = VALUE_BITS'(2);
          out_kind_nxt   = KIND_FACTOR;
          out_last_nxt   = (rest_r == VALUE_BITS'(2));
          rest_nxt       = rest_r >> 1;
        end
        OP_EMIT_DIV: begin
          out_valid_nxt  = 1'b1;
          out_factor_nxt = div_r;
          out_kind_nxt   = KIND_FACTOR;
          out_last_nxt   = 1'b0;
          rest_nxt       = div_quo;
        end
        OP_NEXT_DIV: begin
          div_nxt = div_r + VALUE_BITS'(2);
        end
        OP_EMIT_REST: begin
          out_valid_nxt  = 1'b1;
          out_factor_nxt = rest_r;
          out_kind_nxt   = KIND_FACTOR;
          out_last_nxt   = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rest_r       <= rest_nxt;
    div_r        <= div_nxt;
    out_factor_r <= out_factor_nxt;
    out_kind_r   <= out_kind_nxt;
    out_last_r   <= out_last_nxt;
  end

  // remainder and quotient of rest by the trial divisor
  tdf_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (rest_r),
    .divisor   (div_r),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign out_valid  = out_valid_r;
  assign out_factor = out_factor_r;
  assign out_kind   = out_kind_r;
  assign out_last   = out_last_r;

endmodule

### rtl/tdf_checker.sv
// tdf_checker: port-level checks on the factorizer result channel
// depends on tdf_pkg; bound to trial_division_factorizer below
module tdf_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [tdf_pkg::VALUE_BITS-1:0] out_factor,
  input logic [1:0]                     out_kind,
  input logic                           out_last
);
  import tdf_pkg::*;

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_factor)
      && $stable(out_kind) && $stable(out_last))
    else $error("stalled result word changed");

  // status words carry no factor and close the run
  a_status_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_FACTOR) |-> (out_factor == '0) && out_last)
    else $error("status word malformed");

  // a factor is at least two
  a_factor_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_FACTOR) |-> out_factor >= VALUE_BITS'(2))
    else $error("factor below two");

  // no input taken while a result that is not the last of its run is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("input accepted mid run");

endmodule

bind trial_division_factorizer tdf_checker u_chk (.*);
